[src/gdbo_pkg.sv]
// ----------------------------------------------------------------------------
// gdbo_pkg: shared types for the graph traversal block
// Item opcodes and the one-hot sequencer state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdbo_pkg;

   typedef enum logic [1:0] {
      OP_EDGE  = 2'd0,
      OP_DFS   = 2'd1,
      OP_BFS   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_BAD    = 11'b000_0000_0010,
      ST_EA     = 11'b000_0000_0100,
      ST_EB     = 11'b000_0000_1000,
      ST_EW     = 11'b000_0001_0000,
      ST_PICK   = 11'b000_0010_0000,
      ST_POP    = 11'b000_0100_0000,
      ST_QRD    = 11'b000_1000_0000,
      ST_QDATA  = 11'b001_0000_0000,
      ST_BSCAN  = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

endpackage

[src/graph_dfs_bfs_order.sv]
// ----------------------------------------------------------------------------
// graph_dfs_bfs_order: depth-first / breadth-first visiting order
// Adjacency bit matrix in a memory, one shared lowest-unvisited pick unit,
// and a walk stack/queue memory under a small sequencer.
// ----------------------------------------------------------------------------
// One item is in work at a time; req_ready is high only while the sequencer
// is idle. An edge item does a read-modify-write of both matrix rows through
// the single adjacency port. A depth-first walk sends out each vertex it
// finds, pushes it and descends into it, and backtracks by popping the
// stack; a breadth-first walk dequeues a vertex, sends it out and enqueues
// its unvisited neighbors. Both walks are paced by the single read port of
// the adjacency and walk memories, one priority pick per cycle while no
// output stall holds the walk.
// A bad start gives one item (vertex 0, bad_start and last set).
// Results leave through an output register; the walk stalls only when that
// register is still full. The last flag marks the final vertex of a walk.
`timescale 1ns / 1ps

module graph_dfs_bfs_order
   import gdbo_pkg::*;
#(
   parameter int N_NODES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [5:0] req_node_a,
   input  logic [5:0] req_node_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_vertex,
   output logic       rsp_bad_start,
   output logic       rsp_last
);

   localparam int IDX_W = $clog2(N_NODES);
   localparam int CNT_W = $clog2(N_NODES + 1);
   localparam logic [6:0] N_MAX = 7'(N_NODES);

   // memories
   logic [N_NODES-1:0] adj_mem [N_NODES];
   logic               adj_ok_ff [N_NODES];
   logic [IDX_W-1:0]   st_mem [N_NODES];

   logic [N_NODES-1:0] adj_rd_data_ff;
   logic               adj_rd_ok_ff;
   logic [IDX_W-1:0]   st_rd_data_ff;

   logic               adj_we;
   logic [IDX_W-1:0]   adj_wa;
   logic [N_NODES-1:0] adj_wd;
   logic [IDX_W-1:0]   adj_rd_addr;
   logic               adj_clear;
   logic               st_we;
   logic [IDX_W-1:0]   st_wa;
   logic [IDX_W-1:0]   st_wd;
   logic [IDX_W-1:0]   st_rd_addr;

   // sequencer state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   a_ff, a_in;
   logic [IDX_W-1:0]   b_ff, b_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   pend_ff, pend_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [CNT_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   head_ff, head_in;
   logic [N_NODES-1:0] visited_ff, visited_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         rsp_vertex_ff, rsp_vertex_in;
   logic               rsp_bad_ff, rsp_bad_in;
   logic               rsp_last_ff, rsp_last_in;

   // datapath
   logic [N_NODES-1:0] row_val;
   logic [N_NODES-1:0] cand;
   logic               found;
   logic [IDX_W-1:0]   pick;
   logic               out_free;
   logic [5:0]         a_sub, b_sub;
   logic [IDX_W-1:0]   a_idx, b_idx;
   logic               a_ok, b_ok;
   logic [CNT_W-1:0]   tail_m1, tail_m2;
   logic [CNT_W-1:0]   head_p1, tail_p1;
   logic [5:0]         pend_vertex;

   function automatic logic [IDX_W-1:0] low_idx(input logic [N_NODES-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = N_NODES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = IDX_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [N_NODES-1:0] vbit(input logic [IDX_W-1:0] idx);
      return N_NODES'(1) << idx;
   endfunction

   assign row_val  = adj_rd_ok_ff ? adj_rd_data_ff : '0;
   assign cand     = row_val & ~visited_ff;
   assign found    = |cand;
   assign pick     = low_idx(cand);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign a_sub = req_node_a - 6'd1;
   assign b_sub = req_node_b - 6'd1;
   assign a_idx = a_sub[IDX_W-1:0];
   assign b_idx = b_sub[IDX_W-1:0];
   assign a_ok  = (req_node_a != 6'd0) && ({1'b0, req_node_a} <= N_MAX);
   assign b_ok  = (req_node_b != 6'd0) && ({1'b0, req_node_b} <= N_MAX);

   assign tail_m1 = tail_ff - CNT_W'(1);
   assign tail_m2 = tail_ff - CNT_W'(2);
   assign tail_p1 = tail_ff + CNT_W'(1);
   assign head_p1 = head_ff + CNT_W'(1);

   assign pend_vertex = 6'(7'(pend_ff) + 7'd1);

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vertex    = rsp_vertex_ff;
   assign rsp_bad_start = rsp_bad_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      cur_in      = cur_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      tail_in     = tail_ff;
      head_in     = head_ff;
      visited_in  = visited_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_last_in   = rsp_last_ff;

      adj_we      = 1'b0;
      adj_wa      = a_ff;
      adj_wd      = row_val;
      adj_rd_addr = cur_ff;
      adj_clear   = 1'b0;
      st_we       = 1'b0;
      st_wa       = tail_ff[IDX_W-1:0];
      st_wd       = pick;
      st_rd_addr  = head_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            adj_rd_addr = a_idx;
            if (req_valid) begin
               unique case (op_type'(req_op))
                  OP_EDGE: begin
                     a_in = a_idx;
                     b_in = b_idx;
                     if (a_ok && b_ok) begin
                        state_in = ST_EA;
                     end
                  end
                  OP_CLEAR: begin
                     adj_clear  = 1'b1;
                     visited_in = '0;
                  end
                  OP_DFS, OP_BFS: begin
                     if (!a_ok) begin
                        state_in = ST_BAD;
                     end else begin
                        visited_in = vbit(a_idx);
                        cur_in     = a_idx;
                        pend_in    = a_idx;
                        st_we      = 1'b1;
                        st_wa      = '0;
                        st_wd      = a_idx;
                        tail_in    = CNT_W'(1);
                        head_in    = '0;
                        if (op_type'(req_op) == OP_DFS) begin
                           // start vertex goes out first; its row is read now
                           pend_vld_in = 1'b1;
                           state_in    = ST_PICK;
                        end else begin
                           pend_vld_in = 1'b0;
                           state_in    = ST_QRD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_BAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = 6'd0;
               rsp_bad_in    = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_EA: begin
            adj_rd_addr = a_ff;
            state_in    = ST_EB;
         end

         ST_EB: begin
            adj_we      = 1'b1;
            adj_wa      = a_ff;
            adj_wd      = row_val | vbit(b_ff);
            adj_rd_addr = b_ff;
            state_in    = ST_EW;
         end

         ST_EW: begin
            adj_we   = 1'b1;
            adj_wa   = b_ff;
            adj_wd   = row_val | vbit(a_ff);
            state_in = ST_IDLE;
         end

         ST_PICK: begin
            if (found) begin
               if (out_free) begin
                  // push the found vertex and descend into it
                  rsp_valid_in  = 1'b1;
                  rsp_vertex_in = pend_vertex;
                  rsp_bad_in    = 1'b0;
                  rsp_last_in   = 1'b0;
                  pend_in       = pick;
                  visited_in    = visited_ff | vbit(pick);
                  st_we         = 1'b1;
                  st_wa         = tail_ff[IDX_W-1:0];
                  st_wd         = pick;
                  tail_in       = tail_p1;
                  cur_in        = pick;
                  adj_rd_addr   = pick;
               end
            end else begin
               // backtrack
               tail_in    = tail_m1;
               st_rd_addr = tail_m2[IDX_W-1:0];
               if (tail_m1 == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_POP;
               end
            end
         end

         ST_POP: begin
            cur_in      = st_rd_data_ff;
            adj_rd_addr = st_rd_data_ff;
            state_in    = ST_PICK;
         end

         ST_QRD: begin
            state_in = ST_QDATA;
         end

         ST_QDATA: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_vertex_in = pend_vertex;
                  rsp_bad_in    = 1'b0;
                  rsp_last_in   = 1'b0;
               end
               pend_in     = st_rd_data_ff;
               pend_vld_in = 1'b1;
               head_in     = head_p1;
               cur_in      = st_rd_data_ff;
               adj_rd_addr = st_rd_data_ff;
               state_in    = ST_BSCAN;
            end
         end

         ST_BSCAN: begin
            if (found) begin
               // enqueue one neighbor per cycle
               st_we      = 1'b1;
               st_wa      = tail_ff[IDX_W-1:0];
               st_wd      = pick;
               tail_in    = tail_p1;
               visited_in = visited_ff | vbit(pick);
            end else if (head_ff == tail_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_QRD;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pend_vertex;
               rsp_bad_in    = 1'b0;
               rsp_last_in   = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_vld_ff  <= 1'b0;
         tail_ff      <= '0;
         head_ff      <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_vld_ff  <= pend_vld_in;
         tail_ff      <= tail_in;
         head_ff      <= head_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      cur_ff        <= cur_in;
      pend_ff       <= pend_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_bad_ff    <= rsp_bad_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // adjacency rows: a row without its valid bit reads as no edges
   always_ff @(posedge clock) begin
      if (reset || adj_clear) begin
         for (int i = 0; i < N_NODES; i++) begin
            adj_ok_ff[i] <= 1'b0;
         end
      end else if (adj_we) begin
         adj_ok_ff[adj_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wa] <= adj_wd;
      end
      adj_rd_data_ff <= adj_mem[adj_rd_addr];
      adj_rd_ok_ff   <= adj_ok_ff[adj_rd_addr];
   end

   // walk stack / queue
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
      st_rd_data_ff <= st_mem[st_rd_addr];
   end

endmodule
